/* design/hdlctx_pkg.sv */
// Shared types, constants and helper functions for the HDLC-like frame transmitter.
// The front end, the request queue and the byte sequencer all use this package.
package hdlctx_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7e;
	localparam logic [7:0]  ESC_BYTE  = 8'h7d;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [7:0]  XON_BYTE  = 8'h11;
	localparam logic [7:0]  DC2_BYTE  = 8'h12;
	localparam logic [7:0]  XOFF_BYTE = 8'h13;
	localparam logic [15:0] FCS_INIT  = 16'hffff;
	localparam logic [15:0] FCS_POLY  = 16'h8408;

	localparam int QUEUE_DEPTH = 2;

	// One classified request passed from the front end to the sequencer.
	typedef struct packed {
		logic        open;     // frame opens with this byte: send the start flag first
		logic        last;     // frame closes after this byte
		logic [7:0]  data;
		logic [15:0] fcs;      // complemented FCS, meaningful only when last is set
	} req_t;

	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] v;
		v = fcs ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (v[0])
				v = (v >> 1) ^ FCS_POLY;
			else
				v = v >> 1;
		end
		return v;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == ESC_BYTE) || (b == FLAG_BYTE) || (b == XON_BYTE) ||
			(b == DC2_BYTE) || (b == XOFF_BYTE);
	endfunction

endpackage

/* design/hdlctx_front.sv */
// Front end: accepts body bytes, tracks frame state and runs the FCS-16.
// Depends on hdlctx_pkg; feeds classified requests into hdlctx_queue.
module hdlctx_front import hdlctx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output req_t       push_req
);

	logic [15:0] fcs_q;
	logic        in_frame_q;
	logic [15:0] fcs_start;
	logic [15:0] fcs_next;

	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;
	assign fcs_start = in_frame_q ? fcs_q : FCS_INIT;
	assign fcs_next  = fcs_update(fcs_start, data_byte);

	always_comb begin
		push_req.open = !in_frame_q;
		push_req.last = last_byte;
		push_req.data = data_byte;
		push_req.fcs  = fcs_next ^ FCS_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcs_q      <= FCS_INIT;
			in_frame_q <= 1'b0;
		end else if (push) begin
			fcs_q      <= last_byte ? FCS_INIT : fcs_next;
			in_frame_q <= !last_byte;
		end
	end

endmodule

/* design/hdlctx_queue.sv */
// Short request queue between the front end and the byte sequencer.
// Depends on hdlctx_pkg for the request type.
module hdlctx_queue import hdlctx_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output req_t head_req
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	req_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_req   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* design/hdlctx_seq.sv */
// Byte sequencer: turns each request into flag, escape, data and FCS line bytes.
// Depends on hdlctx_pkg; drives the registered output channel.
module hdlctx_seq import hdlctx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  req_t       head_req,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_OPEN  = 6'b000010,
		PH_DATA  = 6'b000100,
		PH_FCSL  = 6'b001000,
		PH_FCSH  = 6'b010000,
		PH_CLOSE = 6'b100000
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_after;
	logic       esc_q;
	req_t       req_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_end_q;

	logic [7:0] raw;
	logic       escable;
	logic       first_esc;
	logic [7:0] emit_byte;
	logic       rec_done;
	logic       emit_ok;
	logic       fire;

	always_comb begin
		raw         = FLAG_BYTE;
		escable     = 1'b0;
		phase_after = PH_IDLE;
		case (phase_q)
			PH_OPEN: begin
				phase_after = PH_DATA;
			end
			PH_DATA: begin
				raw         = req_q.data;
				escable     = 1'b1;
				phase_after = req_q.last ? PH_FCSL : PH_IDLE;
			end
			PH_FCSL: begin
				raw         = req_q.fcs[7:0];
				escable     = 1'b1;
				phase_after = PH_FCSH;
			end
			PH_FCSH: begin
				raw         = req_q.fcs[15:8];
				escable     = 1'b1;
				phase_after = PH_CLOSE;
			end
			default: begin
				phase_after = PH_IDLE;
			end
		endcase
	end

	// A byte that needs escaping is sent as two line bytes: the escape byte, then the byte XOR 0x20.
	assign first_esc = escable && needs_escape(raw) && !esc_q;
	assign emit_byte = first_esc ? ESC_BYTE : (esc_q ? (raw ^ ESC_XOR) : raw);
	assign rec_done  = !first_esc && (phase_after == PH_IDLE);
	assign emit_ok   = !out_valid_q || !out_stall;
	assign fire      = emit_ok && (phase_q != PH_IDLE);
	assign pop       = head_valid && ((phase_q == PH_IDLE) || (fire && rec_done));

	always_ff @(posedge clk) begin
		if (pop)
			req_q <= head_req;
		if (fire) begin
			out_byte_q  <= emit_byte;
			run_last_q  <= rec_done;
			frame_end_q <= (phase_q == PH_CLOSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= head_req.open ? PH_OPEN : PH_DATA;
				esc_q   <= 1'b0;
			end else if (fire) begin
				esc_q <= first_esc;
				if (!first_esc)
					phase_q <= phase_after;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

endmodule

/* design/hdlc_like_frame_transmitter.sv */
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | data_byte[7:0], last_byte
// output   | out_valid/out_stall| out_byte[7:0], run_last, frame_end
//
// Each request yields one to eight line bytes, one byte per clock from the sequencer while the output is not stalled.
// The front end takes a new request every cycle while the queue has room.
// Reset clears the frame state, FCS, queue and output valid flag; no frame is open after it.
// A stalled output holds its byte; the queue then fills and in_stall rises.
// Top level of the HDLC-like frame transmitter; depends on hdlctx_pkg and its submodules.
module hdlc_like_frame_transmitter import hdlctx_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	logic push;
	req_t push_req;
	logic q_full;
	logic pop;
	logic head_valid;
	req_t head_req;

	hdlctx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_req  (push_req)
	);

	hdlctx_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_req   (head_req)
	);

	hdlctx_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_req   (head_req),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule
